FILE: design/pulse_beat_rate_and_rmssd_defines.svh
// Assertion macros used by the back part of the pulse beat rate and RMSSD design.
`ifndef PULSE_BEAT_RATE_AND_RMSSD_DEFINES_SVH
`define PULSE_BEAT_RATE_AND_RMSSD_DEFINES_SVH

// ante holds at an edge: cons holds at the same edge
`define PBR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbr assertion failed");

// ante holds at an edge: cons holds at the next edge
`define PBR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbr assertion failed");

`endif

FILE: design/pbr_pkg.sv
// Package: shared types, register codes and constants of the beat rate block.
package pbr_pkg;

   localparam int SAMPLE_W = 18;
   localparam int TIME_W   = 32;
   localparam int GAP_W    = 12;
   localparam int RATE_W   = 8;
   localparam int VAR_W    = 11;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;

   localparam logic [31:0] RATE_NUMERATOR = 32'd60000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FINGER_LEVEL  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP       = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH       = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRACTION      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VAR       = 4'd7;

   typedef struct packed {
      logic [16:0] finger_level;
      logic [11:0] min_gap;
      logic [11:0] max_gap;
      logic [15:0] refresh;
      logic [7:0]  fraction;
      logic [7:0]  min_rate;
      logic [7:0]  max_rate;
      logic [10:0] max_var;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      finger_level: 17'd50000,
      min_gap:      12'd300,
      max_gap:      12'd2000,
      refresh:      16'd1000,
      fraction:     8'd179,
      min_rate:     8'd30,
      max_rate:     8'd220,
      max_var:      11'd500
   };

   typedef struct packed {
      logic             finger;
      logic             beat;
      logic             store;
      logic [GAP_W-1:0] gap;
   } task_type;

   typedef struct packed {
      logic              finger;
      logic              beat;
      logic [RATE_W-1:0] rate;
      logic [VAR_W-1:0]  variability;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RATE_RD,
      BK_RATE_AVG,
      BK_RATE_DIV,
      BK_VAR_RD,
      BK_VAR_DIV,
      BK_SQRT,
      BK_OUT
   } back_state_type;

   // zero a rate outside the band; 256 stands for any rate above 255
   function automatic logic [RATE_W-1:0] rate_in_band(logic [8:0] r, logic [7:0] lo,
                                                     logic [7:0] hi);
      logic [RATE_W-1:0] res;
      res = ((r < {1'b0, lo}) || (r > {1'b0, hi})) ? '0 : r[RATE_W-1:0];
      return res;
   endfunction

endpackage

FILE: design/pbr_queue.sv
// Small first-in first-out queue used between the block's parts.
module pbr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: design/pbr_front.sv
// Front part: finger check, peak detector and beat interval qualification.
module pbr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic signed [pbr_pkg::SAMPLE_W-1:0] ir_sample,
   input  logic [pbr_pkg::TIME_W-1:0]          time_ms,
   input  pbr_pkg::cfg_type                    cfg,
   output pbr_pkg::task_type                   task_out
);

   logic signed [pbr_pkg::SAMPLE_W-1:0] prev_ff, prev_in, thr_ff, thr_in;
   logic                                rising_ff, rising_in;
   logic [pbr_pkg::TIME_W-1:0]          peak_ff, peak_in, last_ff, last_in;

   logic                                finger, beat, store;
   logic [pbr_pkg::TIME_W-1:0]          since_peak, gap;
   logic [24:0]                         scaled;
   logic signed [pbr_pkg::SAMPLE_W-1:0] thr_use;

   always_comb begin
      finger     = (ir_sample >= $signed({1'b0, cfg.finger_level}));
      since_peak = time_ms - peak_ff;
      // sample is not negative here whenever it matters
      scaled     = ir_sample[16:0] * cfg.fraction;
      thr_use    = (since_peak > {16'd0, cfg.refresh}) ? $signed({1'b0, scaled[24:8]}) : thr_ff;
      gap        = time_ms - last_ff;

      prev_in   = prev_ff;
      thr_in    = thr_ff;
      rising_in = rising_ff;
      peak_in   = peak_ff;
      last_in   = last_ff;
      beat      = 1'b0;

      if (accept && finger) begin
         thr_in  = thr_use;
         prev_in = ir_sample;
         if (ir_sample > prev_ff) begin
            rising_in = 1'b1;
         end else if (rising_ff && (ir_sample < prev_ff)) begin
            rising_in = 1'b0;
            if ((ir_sample > thr_use) && (prev_ff > thr_use)) begin
               beat    = 1'b1;
               peak_in = time_ms;
               last_in = time_ms;
            end
         end
      end

      store = beat && (gap > {20'd0, cfg.min_gap}) && (gap < {20'd0, cfg.max_gap});

      task_out.finger = finger;
      task_out.beat   = beat;
      task_out.store  = store;
      task_out.gap    = gap[pbr_pkg::GAP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         thr_ff    <= '0;
         rising_ff <= 1'b0;
         peak_ff   <= '0;
         last_ff   <= '0;
      end else begin
         prev_ff   <= prev_in;
         thr_ff    <= thr_in;
         rising_ff <= rising_in;
         peak_ff   <= peak_in;
         last_ff   <= last_in;
      end
   end

endmodule

FILE: design/pbr_div.sv
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
module pbr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] dvd_ff, dvd_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] rem_sh;
   logic        ge;

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_comb begin
      rem_sh  = {rem_ff[15:0], dvd_ff[31]};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift quotient bits in where the dividend bits leave
         rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         dvd_in = {dvd_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

FILE: design/pbr_back.sv
// Back part: interval ring, rate averaging and division, RMSSD and square root.
`include "pulse_beat_rate_and_rmssd_defines.svh"

module pbr_back #(
   parameter int RING_DEPTH         = 32,
   parameter int RATE_WINDOW        = 8,
   parameter int VARIABILITY_WINDOW = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pbr_pkg::cfg_type       cfg,
   input  logic                   tq_empty,
   input  pbr_pkg::task_type      tq_data,
   output logic                   tq_pop,
   input  logic                   rq_full,
   output logic                   rq_push,
   output pbr_pkg::result_type    rq_data
);

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int MAX_RD = (RATE_WINDOW > VARIABILITY_WINDOW + 1) ?
                           RATE_WINDOW : VARIABILITY_WINDOW + 1;
   localparam int ISS_W  = $clog2(MAX_RD + 1);

   pbr_pkg::back_state_type state_ff, state_in;

   logic [pbr_pkg::GAP_W-1:0] ring_mem [RING_DEPTH];
   logic [pbr_pkg::GAP_W-1:0] rd_data_ff;
   logic                      ring_we;

   logic [PTR_W-1:0]  wi_ff, wi_in, ptr_ff, ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in, fill_inc;
   logic [ISS_W-1:0]  need_ff, need_in, issue_ff, issue_in, rate_need, var_need;
   logic              rd_pend_ff, rd_pend_in, sq_pend_ff, sq_pend_in;
   logic              have_prev_ff, have_prev_in;
   logic [pbr_pkg::GAP_W-1:0] prev_ff, prev_in, diff;
   logic [23:0]       sq_ff, sq_in;
   logic [31:0]       acc_ff, acc_in, rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic [31:0]       root_try;
   logic [pbr_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [pbr_pkg::VAR_W-1:0]  var_ff, var_in;
   logic              fin_ff, fin_in, beat_ff, beat_in;
   logic              div_on_ff, div_on_in;
   logic              issuing, reads_done;
   logic [8:0]        rate9;

   logic              div_start, div_busy, div_done;
   logic [31:0]       div_dvd, div_quo;
   logic [15:0]       div_dvs;

   pbr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      fill_inc  = (fill_ff == CNT_W'(RING_DEPTH)) ? fill_ff : fill_ff + CNT_W'(1);
      rate_need = (int'(fill_inc) < RATE_WINDOW) ? ISS_W'(fill_inc) : ISS_W'(RATE_WINDOW);
      // one more read than differences
      var_need  = ((int'(fill_ff) - 1) < VARIABILITY_WINDOW) ?
                  ISS_W'(fill_ff) : ISS_W'(VARIABILITY_WINDOW + 1);
      issuing    = (issue_ff != need_ff);
      reads_done = !issuing && !rd_pend_ff && !sq_pend_ff;
      diff       = (rd_data_ff > prev_ff) ? rd_data_ff - prev_ff : prev_ff - rd_data_ff;
      root_try   = root_ff + bit_ff;
      rate9      = (div_quo > 32'd255) ? 9'd256 : div_quo[8:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbr_pkg::BK_IDLE: begin
            if (!tq_empty) begin
               if (tq_data.finger && tq_data.store) begin
                  state_in = pbr_pkg::BK_RATE_RD;
               end else if (fill_ff < CNT_W'(2)) begin
                  state_in = pbr_pkg::BK_OUT;
               end else begin
                  state_in = pbr_pkg::BK_VAR_RD;
               end
            end
         end
         pbr_pkg::BK_RATE_RD: begin
            if (reads_done) state_in = pbr_pkg::BK_RATE_AVG;
         end
         pbr_pkg::BK_RATE_AVG: begin
            if (div_done) state_in = pbr_pkg::BK_RATE_DIV;
         end
         pbr_pkg::BK_RATE_DIV: begin
            if (acc_ff == '0 || div_done) begin
               state_in = (fill_ff < CNT_W'(2)) ? pbr_pkg::BK_OUT : pbr_pkg::BK_VAR_RD;
            end
         end
         pbr_pkg::BK_VAR_RD: begin
            if (reads_done) state_in = pbr_pkg::BK_VAR_DIV;
         end
         pbr_pkg::BK_VAR_DIV: begin
            if (div_done) state_in = pbr_pkg::BK_SQRT;
         end
         pbr_pkg::BK_SQRT: begin
            if (bit_ff == '0) state_in = pbr_pkg::BK_OUT;
         end
         pbr_pkg::BK_OUT: begin
            if (!rq_full) state_in = pbr_pkg::BK_IDLE;
         end
         default: state_in = pbr_pkg::BK_IDLE;
      endcase
   end

   // datapath and strobes
   always_comb begin
      wi_in        = wi_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      need_in      = need_ff;
      issue_in     = issue_ff;
      rd_pend_in   = 1'b0;
      sq_pend_in   = 1'b0;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      rate_in      = rate_ff;
      var_in       = var_ff;
      fin_in       = fin_ff;
      beat_in      = beat_ff;
      div_on_in    = div_on_ff;
      div_start    = 1'b0;
      div_dvd      = acc_ff;
      div_dvs      = 16'(need_ff);
      tq_pop       = 1'b0;
      rq_push      = 1'b0;
      ring_we      = 1'b0;

      // walk the ring from the newest entry back
      if (state_ff == pbr_pkg::BK_RATE_RD || state_ff == pbr_pkg::BK_VAR_RD) begin
         if (issuing) begin
            issue_in   = issue_ff + ISS_W'(1);
            ptr_in     = (ptr_ff == '0) ? PTR_W'(RING_DEPTH - 1) : ptr_ff - PTR_W'(1);
            rd_pend_in = 1'b1;
         end
      end

      unique case (state_ff)
         pbr_pkg::BK_IDLE: begin
            if (!tq_empty) begin
               tq_pop  = 1'b1;
               fin_in  = tq_data.finger;
               beat_in = tq_data.beat;
               if (!tq_data.finger) begin
                  rate_in = '0;
               end else if (tq_data.store) begin
                  ring_we  = 1'b1;
                  wi_in    = (wi_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wi_ff + PTR_W'(1);
                  fill_in  = fill_inc;
                  ptr_in   = wi_ff;
                  need_in  = rate_need;
                  issue_in = '0;
                  acc_in   = '0;
               end else begin
                  rate_in = pbr_pkg::rate_in_band({1'b0, rate_ff}, cfg.min_rate, cfg.max_rate);
               end
               if (!(tq_data.finger && tq_data.store)) begin
                  ptr_in       = (wi_ff == '0) ? PTR_W'(RING_DEPTH - 1) : wi_ff - PTR_W'(1);
                  need_in      = var_need;
                  issue_in     = '0;
                  acc_in       = '0;
                  have_prev_in = 1'b0;
                  if (fill_ff < CNT_W'(2)) var_in = '0;
               end
            end
         end
         pbr_pkg::BK_RATE_RD: begin
            if (rd_pend_ff) acc_in = acc_ff + 32'(rd_data_ff);
         end
         pbr_pkg::BK_RATE_AVG: begin
            div_dvd = acc_ff;
            div_dvs = 16'(need_ff);
            if (!div_on_ff) begin
               div_start = 1'b1;
               div_on_in = 1'b1;
            end else if (div_done) begin
               div_on_in = 1'b0;
               acc_in    = div_quo;
            end
         end
         pbr_pkg::BK_RATE_DIV: begin
            div_dvd = pbr_pkg::RATE_NUMERATOR;
            div_dvs = acc_ff[15:0];
            if (acc_ff == '0) begin
               rate_in = '0;
            end else if (!div_on_ff) begin
               div_start = 1'b1;
               div_on_in = 1'b1;
            end else if (div_done) begin
               div_on_in = 1'b0;
               rate_in   = pbr_pkg::rate_in_band(rate9, cfg.min_rate, cfg.max_rate);
            end
            if (acc_ff == '0 || div_done) begin
               ptr_in       = (wi_ff == '0) ? PTR_W'(RING_DEPTH - 1) : wi_ff - PTR_W'(1);
               need_in      = var_need;
               issue_in     = '0;
               acc_in       = '0;
               have_prev_in = 1'b0;
               if (fill_ff < CNT_W'(2)) var_in = '0;
            end
         end
         pbr_pkg::BK_VAR_RD: begin
            if (rd_pend_ff) begin
               prev_in      = rd_data_ff;
               have_prev_in = 1'b1;
               sq_in        = diff * diff;
               sq_pend_in   = have_prev_ff;
            end
            if (sq_pend_ff) acc_in = acc_ff + 32'(sq_ff);
         end
         pbr_pkg::BK_VAR_DIV: begin
            div_dvd = acc_ff;
            div_dvs = 16'(need_ff - ISS_W'(1));
            if (!div_on_ff) begin
               div_start = 1'b1;
               div_on_in = 1'b1;
            end else if (div_done) begin
               div_on_in = 1'b0;
               rem_in    = div_quo;
               root_in   = '0;
               bit_in    = 32'h4000_0000;
            end
         end
         pbr_pkg::BK_SQRT: begin
            if (bit_ff != '0) begin
               if (rem_ff >= root_try) begin
                  rem_in  = rem_ff - root_try;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else begin
               var_in = (root_ff > {21'd0, cfg.max_var}) ? '0 : root_ff[pbr_pkg::VAR_W-1:0];
            end
         end
         pbr_pkg::BK_OUT: begin
            rq_push = !rq_full;
         end
         default: begin
         end
      endcase

      rq_data.finger      = fin_ff;
      rq_data.beat        = beat_ff;
      rq_data.rate        = rate_ff;
      rq_data.variability = var_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pbr_pkg::BK_IDLE;
         wi_ff      <= '0;
         fill_ff    <= '0;
         rate_ff    <= '0;
         var_ff     <= '0;
         rd_pend_ff <= 1'b0;
         sq_pend_ff <= 1'b0;
         div_on_ff  <= 1'b0;
         issue_ff   <= '0;
         need_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         wi_ff      <= wi_in;
         fill_ff    <= fill_in;
         rate_ff    <= rate_in;
         var_ff     <= var_in;
         rd_pend_ff <= rd_pend_in;
         sq_pend_ff <= sq_pend_in;
         div_on_ff  <= div_on_in;
         issue_ff   <= issue_in;
         need_ff    <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      have_prev_ff <= have_prev_in;
      prev_ff      <= prev_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      fin_ff       <= fin_in;
      beat_ff      <= beat_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wi_ff] <= tq_data.gap;
      end
      rd_data_ff <= ring_mem[ptr_ff];
   end

   `PBR_ASSERT_IMP(a_div_start_idle, clock, reset, div_start, !div_busy)
   `PBR_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(RING_DEPTH))
   `PBR_ASSERT_NXT(a_store_fills, clock, reset, ring_we, fill_ff != '0)
   `PBR_ASSERT_IMP(a_push_in_out, clock, reset, rq_push, state_ff == pbr_pkg::BK_OUT)

endmodule

FILE: design/pulse_beat_rate_and_rmssd.sv
// Top level: beat detection front, beat queue, rate and RMSSD back, result queue.
//
//   channel   direction  handshake             payload
//   req_      in         req_push / req_full   ir_sample, time_ms
//   rsp_      out        rsp_pop / rsp_empty   finger_present, beat_seen, rate_bpm,
//                                              variability_ms
//   csr_      in         csr_valid / csr_ready csr_index, csr_wdata
//
// The front classifies a sample in the cycle it is taken. While fewer than two intervals are
// stored and none is added, the back goes straight to its output state; otherwise it reads the
// ring one entry a cycle for the rate mean (when an interval is stored) and for the RMSSD (once
// two are stored), and runs the shared divider (once for RMSSD, two more times when an interval
// is stored) and then the square root.
// Two-entry queues sit between front and back and on the result side; a full result
// queue holds the back in its output state. Reset is synchronous; the ring holds no reset.
module pulse_beat_rate_and_rmssd #(
   parameter int RING_DEPTH         = 32,
   parameter int RATE_WINDOW        = 8,
   parameter int VARIABILITY_WINDOW = 30
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [pbr_pkg::SAMPLE_W-1:0]   req_ir_sample,
   input  logic [pbr_pkg::TIME_W-1:0]            req_time_ms,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic                                  rsp_finger_present,
   output logic                                  rsp_beat_seen,
   output logic [pbr_pkg::RATE_W-1:0]            rsp_rate_bpm,
   output logic [pbr_pkg::VAR_W-1:0]             rsp_variability_ms,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pbr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pbr_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   pbr_pkg::cfg_type    cfg_ff, cfg_in;
   pbr_pkg::task_type   front_task, tq_data;
   pbr_pkg::result_type rq_in, rq_out;
   logic                tq_full, tq_empty, tq_pop, rq_full, rq_push;
   logic                accept;

   assign csr_ready = 1'b1;
   assign req_full  = tq_full;
   assign accept    = req_push && !tq_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pbr_pkg::CSR_FINGER_LEVEL: cfg_in.finger_level = csr_wdata[16:0];
            pbr_pkg::CSR_MIN_GAP:      cfg_in.min_gap      = csr_wdata[11:0];
            pbr_pkg::CSR_MAX_GAP:      cfg_in.max_gap      = csr_wdata[11:0];
            pbr_pkg::CSR_REFRESH:      cfg_in.refresh      = csr_wdata[15:0];
            pbr_pkg::CSR_FRACTION:     cfg_in.fraction     = csr_wdata[7:0];
            pbr_pkg::CSR_MIN_RATE:     cfg_in.min_rate     = csr_wdata[7:0];
            pbr_pkg::CSR_MAX_RATE:     cfg_in.max_rate     = csr_wdata[7:0];
            pbr_pkg::CSR_MAX_VAR:      cfg_in.max_var      = csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pbr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ir_sample (req_ir_sample),
      .time_ms   (req_time_ms),
      .cfg       (cfg_ff),
      .task_out  (front_task)
   );

   pbr_queue #(
      .WIDTH ($bits(pbr_pkg::task_type)),
      .DEPTH (2)
   ) u_task_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_task),
      .full      (tq_full),
      .pop       (tq_pop),
      .empty     (tq_empty),
      .pop_data  (tq_data)
   );

   pbr_back #(
      .RING_DEPTH         (RING_DEPTH),
      .RATE_WINDOW        (RATE_WINDOW),
      .VARIABILITY_WINDOW (VARIABILITY_WINDOW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .tq_empty (tq_empty),
      .tq_data  (tq_data),
      .tq_pop   (tq_pop),
      .rq_full  (rq_full),
      .rq_push  (rq_push),
      .rq_data  (rq_in)
   );

   pbr_queue #(
      .WIDTH ($bits(pbr_pkg::result_type)),
      .DEPTH (2)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_in),
      .full      (rq_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rq_out)
   );

   assign rsp_finger_present = rq_out.finger;
   assign rsp_beat_seen      = rq_out.beat;
   assign rsp_rate_bpm       = rq_out.rate;
   assign rsp_variability_ms = rq_out.variability;

endmodule
